// File: src/fdvp_pkg.sv
package fdvp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_DISTANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_CENTER = 3'd6;

    localparam logic signed [15:0] COS_ANGLE_RST     = 16'sd16384;
    localparam logic signed [15:0] SIN_ANGLE_RST     = 16'sd0;
    localparam logic [14:0]        EYE_DISTANCE_RST  = 15'd8192;
    localparam logic [14:0]        CAMERA_OFFSET_RST = 15'd20480;
    localparam logic [14:0]        FOV_SCALE_RST     = 15'd17157;
    localparam logic [9:0]         SCREEN_SCALE_RST  = 10'd300;
    localparam logic [9:0]         SCREEN_CENTER_RST = 10'd200;

    // first divider: 31-bit dividend, 19-bit divisor (2q)
    localparam int D1_STEPS = 31;
    // second divider: 17 quotient bits, larger quotients saturate anyway
    localparam int D2_STEPS = 17;

    // valid shift line positions
    localparam int V_S1   = 0;
    localparam int V_S2   = 1;
    localparam int V_D1   = 2;
    localparam int V_S4   = V_D1 + D1_STEPS + 1;
    localparam int V_S5   = V_S4 + 1;
    localparam int V_D2   = V_S5 + 1;
    localparam int V_OUT  = V_D2 + D2_STEPS + 1;
    localparam int PIPE_LEN = V_OUT + 1;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] vw;
    } in_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               depth_fault;
    } out_t;

    typedef struct packed {
        logic [18:0] rem;
        logic [30:0] nq;
    } d1_lane_t;

    typedef struct packed {
        logic              fault;
        logic [18:0]       b;
        logic [2:0]        neg;
        d1_lane_t [2:0]    lane;
    } d1_stage_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [16:0] nq;
    } d2_lane_t;

    typedef struct packed {
        logic              fault;
        logic [1:0]        ovf;
        logic [30:0]       d;
        logic [1:0]        neg;
        d2_lane_t [1:0]    lane;
    } d2_stage_t;

endpackage

// File: src/four_d_vertex_projector.sv
// Projects one 4D vertex per clock to a screen point in 1/16 pixel. The
// pipeline holds two restoring dividers built as one stage per quotient bit
// (31 stages for the 4D-to-3D divide, 17 for the perspective divide) plus
// multiply, add and rounding stages. The whole pipeline advances whenever the
// output register is empty or being taken, so a new vertex is accepted every
// cycle unless the output register is full and stalled.
// Configuration registers are read live by the stages and must only be written
// while the pipeline is empty.
module four_d_vertex_projector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fdvp_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fdvp_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [fdvp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdvp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    function automatic fdvp_pkg::d1_lane_t d1_step(fdvp_pkg::d1_lane_t l, logic [18:0] b);
        logic [19:0]        t;
        fdvp_pkg::d1_lane_t r;
        t = {l.rem, l.nq[30]};
        if (t >= {1'b0, b})
        begin
            r.rem = 19'(t - {1'b0, b});
            r.nq  = {l.nq[29:0], 1'b1};
        end
        else
        begin
            r.rem = t[18:0];
            r.nq  = {l.nq[29:0], 1'b0};
        end
        return r;
    endfunction

    function automatic fdvp_pkg::d2_lane_t d2_step(fdvp_pkg::d2_lane_t l, logic [30:0] d);
        logic [31:0]        t;
        fdvp_pkg::d2_lane_t r;
        t = {l.rem, l.nq[16]};
        if (t >= {1'b0, d})
        begin
            r.rem = 31'(t - {1'b0, d});
            r.nq  = {l.nq[15:0], 1'b1};
        end
        else
        begin
            r.rem = t[30:0];
            r.nq  = {l.nq[15:0], 1'b0};
        end
        return r;
    endfunction

    // configuration
    logic signed [15:0] cos_angle_reg;
    logic signed [15:0] sin_angle_reg;
    logic [14:0]        eye_distance_reg;
    logic [14:0]        camera_offset_reg;
    logic [14:0]        fov_scale_reg;
    logic [9:0]         screen_scale_reg;
    logic [9:0]         screen_center_reg;
    logic [24:0]        k_reg;

    logic [fdvp_pkg::PIPE_LEN-1:0] valid_reg;
    logic                          en;

    // stage 1: products
    logic signed [31:0] cz_reg, sw_reg, sz_reg, cw_reg;
    logic signed [31:0] cx_reg, sy_reg, sx_reg, cy_reg;

    // stage 2: rotated vertex and 4D divisor
    logic signed [18:0] x1_reg, y1_reg, z1_reg;
    logic signed [19:0] q_reg;
    logic               f1_reg;
    logic signed [18:0] x1_next, y1_next, z1_next, w1_next;
    logic signed [19:0] q_next;

    // first divider
    fdvp_pkg::d1_stage_t d1_reg [0:fdvp_pkg::D1_STEPS];
    fdvp_pkg::d1_stage_t d1_next;

    // stage 4: projected point and depth
    logic signed [30:0] xp_reg, zp_reg;
    logic signed [31:0] d_reg;
    logic               f2_reg;
    logic signed [30:0] xp_next, yp_next, zp_next;
    logic signed [31:0] d_next;

    // stage 5: scaled numerators
    logic signed [56:0] px_reg, pz_reg;
    logic signed [31:0] d5_reg;
    logic               f5_reg;
    logic signed [25:0] k_s;

    // second divider
    fdvp_pkg::d2_stage_t d2_reg [0:fdvp_pkg::D2_STEPS];
    fdvp_pkg::d2_stage_t d2_next;

    fdvp_pkg::out_t out_data_reg;
    fdvp_pkg::out_t out_next;

    assign en        = !valid_reg[fdvp_pkg::V_OUT] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = valid_reg[fdvp_pkg::V_OUT];
    assign out_data  = out_data_reg;
    assign k_s       = {1'b0, k_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            cos_angle_reg     <= fdvp_pkg::COS_ANGLE_RST;
            sin_angle_reg     <= fdvp_pkg::SIN_ANGLE_RST;
            eye_distance_reg  <= fdvp_pkg::EYE_DISTANCE_RST;
            camera_offset_reg <= fdvp_pkg::CAMERA_OFFSET_RST;
            fov_scale_reg     <= fdvp_pkg::FOV_SCALE_RST;
            screen_scale_reg  <= fdvp_pkg::SCREEN_SCALE_RST;
            screen_center_reg <= fdvp_pkg::SCREEN_CENTER_RST;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[fdvp_pkg::PIPE_LEN-2:0], in_valid};
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fdvp_pkg::CFG_COS_ANGLE:     cos_angle_reg     <= cfg_wdata;
                    fdvp_pkg::CFG_SIN_ANGLE:     sin_angle_reg     <= cfg_wdata;
                    fdvp_pkg::CFG_EYE_DISTANCE:  eye_distance_reg  <= cfg_wdata[14:0];
                    fdvp_pkg::CFG_CAMERA_OFFSET: camera_offset_reg <= cfg_wdata[14:0];
                    fdvp_pkg::CFG_FOV_SCALE:     fov_scale_reg     <= cfg_wdata[14:0];
                    fdvp_pkg::CFG_SCREEN_SCALE:  screen_scale_reg  <= cfg_wdata[9:0];
                    fdvp_pkg::CFG_SCREEN_CENTER: screen_center_reg <= cfg_wdata[9:0];
                    default: ;
                endcase
            end
        end
    end

    // stage 2: sums with round half up, q = eye - w1
    always_comb
    begin
        logic signed [32:0] sum_z, sum_w, sum_x, sum_y;
        logic signed [32:0] r_z, r_w, r_x, r_y;
        logic signed [19:0] eye_s;
        sum_z = 33'(cz_reg) - 33'(sw_reg);
        sum_w = 33'(sz_reg) + 33'(cw_reg);
        sum_x = 33'(cx_reg) - 33'(sy_reg);
        sum_y = 33'(sx_reg) + 33'(cy_reg);
        r_z = (sum_z + 33'sd8192) >>> 14;
        r_w = (sum_w + 33'sd8192) >>> 14;
        r_x = (sum_x + 33'sd8192) >>> 14;
        r_y = (sum_y + 33'sd8192) >>> 14;
        z1_next = r_z[18:0];
        w1_next = r_w[18:0];
        x1_next = r_x[18:0];
        y1_next = r_y[18:0];
        eye_s   = {5'd0, eye_distance_reg};
        q_next  = eye_s - 20'(w1_next);
    end

    // first divider load: floor((8192*v + q) / 2q), negatives through one's complement
    always_comb
    begin
        logic signed [31:0] m [3];
        logic signed [18:0] v [3];
        v[0] = x1_reg;
        v[1] = y1_reg;
        v[2] = z1_reg;
        d1_next.fault = f1_reg;
        d1_next.b     = {q_reg[17:0], 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (32'(v[i]) <<< 13) + 32'(q_reg);
            d1_next.neg[i]      = m[i][31];
            d1_next.lane[i].rem = '0;
            d1_next.lane[i].nq  = m[i][31] ? ~m[i][30:0] : m[i][30:0];
        end
    end

    // stage 4: quotients back to signed, depth d = yp + offset
    always_comb
    begin
        fdvp_pkg::d1_stage_t s;
        s = d1_reg[fdvp_pkg::D1_STEPS];
        xp_next = s.neg[0] ? ~s.lane[0].nq : s.lane[0].nq;
        yp_next = s.neg[1] ? ~s.lane[1].nq : s.lane[1].nq;
        zp_next = s.neg[2] ? ~s.lane[2].nq : s.lane[2].nq;
        d_next  = 32'(yp_next) + {17'd0, camera_offset_reg};
    end

    // second divider load: floor(floor((512d - k*p) / 1024) / d)
    always_comb
    begin
        logic signed [56:0] xnum [2];
        logic signed [56:0] m2   [2];
        logic [45:0]        u2   [2];
        xnum[0] = (57'(d5_reg) <<< 9) - px_reg;
        xnum[1] = (57'(d5_reg) <<< 9) - pz_reg;
        d2_next.fault = f5_reg;
        d2_next.d     = d5_reg[30:0];
        for (int i = 0; i < 2; i++)
        begin
            m2[i] = xnum[i] >>> 10;
            d2_next.neg[i] = m2[i][46];
            u2[i] = m2[i][46] ? ~m2[i][45:0] : m2[i][45:0];
            d2_next.ovf[i]      = {2'd0, u2[i][45:17]} >= d5_reg[30:0];
            d2_next.lane[i].rem = {2'd0, u2[i][45:17]};
            d2_next.lane[i].nq  = u2[i][16:0];
        end
    end

    // output: add center, saturate, fault forces zero
    always_comb
    begin
        fdvp_pkg::d2_stage_t s;
        logic [16:0]        qu  [2];
        logic signed [17:0] qs  [2];
        logic signed [18:0] sum [2];
        logic signed [15:0] sat [2];
        s = d2_reg[fdvp_pkg::D2_STEPS];
        for (int i = 0; i < 2; i++)
        begin
            qu[i]  = s.ovf[i] ? '1 : s.lane[i].nq;
            qs[i]  = s.neg[i] ? ~{1'b0, qu[i]} : {1'b0, qu[i]};
            sum[i] = 19'(qs[i]) + 19'({screen_center_reg, 4'd0});
            if (sum[i] > 19'sd32767)
            begin
                sat[i] = 16'sd32767;
            end
            else if (sum[i] < -19'sd32768)
            begin
                sat[i] = -16'sd32768;
            end
            else
            begin
                sat[i] = sum[i][15:0];
            end
        end
        out_next.screen_x    = s.fault ? '0 : sat[0];
        out_next.screen_y    = s.fault ? '0 : sat[1];
        out_next.depth_fault = s.fault;
    end

    always_ff @(posedge clk)
    begin
        k_reg <= 25'(screen_scale_reg * fov_scale_reg);
        if (en)
        begin
            cz_reg <= 32'(cos_angle_reg) * 32'(in_data.vz);
            sw_reg <= 32'(sin_angle_reg) * 32'(in_data.vw);
            sz_reg <= 32'(sin_angle_reg) * 32'(in_data.vz);
            cw_reg <= 32'(cos_angle_reg) * 32'(in_data.vw);
            cx_reg <= 32'(cos_angle_reg) * 32'(in_data.vx);
            sy_reg <= 32'(sin_angle_reg) * 32'(in_data.vy);
            sx_reg <= 32'(sin_angle_reg) * 32'(in_data.vx);
            cy_reg <= 32'(cos_angle_reg) * 32'(in_data.vy);

            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
            q_reg  <= q_next;
            f1_reg <= q_next[19] || (q_next == '0);

            d1_reg[0] <= d1_next;
            for (int i = 0; i < fdvp_pkg::D1_STEPS; i++)
            begin
                d1_reg[i+1].fault <= d1_reg[i].fault;
                d1_reg[i+1].b     <= d1_reg[i].b;
                d1_reg[i+1].neg   <= d1_reg[i].neg;
                for (int j = 0; j < 3; j++)
                begin
                    d1_reg[i+1].lane[j] <= d1_step(d1_reg[i].lane[j], d1_reg[i].b);
                end
            end

            xp_reg <= xp_next;
            zp_reg <= zp_next;
            d_reg  <= d_next;
            f2_reg <= d1_reg[fdvp_pkg::D1_STEPS].fault || d_next[31] || (d_next == '0);

            px_reg <= 57'(xp_reg) * 57'(k_s);
            pz_reg <= 57'(zp_reg) * 57'(k_s);
            d5_reg <= d_reg;
            f5_reg <= f2_reg;

            d2_reg[0] <= d2_next;
            for (int i = 0; i < fdvp_pkg::D2_STEPS; i++)
            begin
                d2_reg[i+1].fault <= d2_reg[i].fault;
                d2_reg[i+1].ovf   <= d2_reg[i].ovf;
                d2_reg[i+1].d     <= d2_reg[i].d;
                d2_reg[i+1].neg   <= d2_reg[i].neg;
                for (int j = 0; j < 2; j++)
                begin
                    d2_reg[i+1].lane[j] <= d2_step(d2_reg[i].lane[j], d2_reg[i].d);
                end
            end

            out_data_reg <= out_next;
        end
    end

endmodule

// File: tb/fdvp_checker.sv
`timescale 1ns / 1ps

module fdvp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  fdvp_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  fdvp_pkg::out_t                  out_data,
    input  logic                            cfg_we,
    input  logic [fdvp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdvp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending
);

    longint         cos_r, sin_r, eye_r, cam_r, fov_r, scl_r, ctr_r;
    fdvp_pkg::out_t screen_q[$];

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint rdiv(longint a, longint b);
        return fdiv(2 * a + b, 2 * b);
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic fdvp_pkg::out_t project_vertex(fdvp_pkg::in_t v);
        fdvp_pkg::out_t r;
        longint x, y, z, w, z1, w1, x1, y1, q, xp, yp, zp, d, k;
        x = v.vx;
        y = v.vy;
        z = v.vz;
        w = v.vw;
        z1 = rdiv(cos_r * z - sin_r * w, 16384);
        w1 = rdiv(sin_r * z + cos_r * w, 16384);
        x1 = rdiv(cos_r * x - sin_r * y, 16384);
        y1 = rdiv(sin_r * x + cos_r * y, 16384);
        r = '0;
        q = eye_r - w1;
        if (q <= 0)
        begin
            r.depth_fault = 1'b1;
            return r;
        end
        xp = rdiv(x1 * 4096, q);
        yp = rdiv(y1 * 4096, q);
        zp = rdiv(z1 * 4096, q);
        d = yp + cam_r;
        if (d <= 0)
        begin
            r.depth_fault = 1'b1;
            return r;
        end
        k = scl_r * fov_r;
        r.screen_x = clamp16(ctr_r * 16 + rdiv(-(k * xp), d * 1024));
        r.screen_y = clamp16(ctr_r * 16 + rdiv(-(k * zp), d * 1024));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fdvp_pkg::out_t e;
        if (!rst_n)
        begin
            cos_r = fdvp_pkg::COS_ANGLE_RST;
            sin_r = fdvp_pkg::SIN_ANGLE_RST;
            eye_r = fdvp_pkg::EYE_DISTANCE_RST;
            cam_r = fdvp_pkg::CAMERA_OFFSET_RST;
            fov_r = fdvp_pkg::FOV_SCALE_RST;
            scl_r = fdvp_pkg::SCREEN_SCALE_RST;
            ctr_r = fdvp_pkg::SCREEN_CENTER_RST;
            fail_count = 0;
            screen_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (screen_q.size() == 0)
                begin
                    $display("%0t: unexpected output transaction %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    e = screen_q.pop_front();
                    if (out_data.screen_x !== e.screen_x)
                    begin
                        $display("%0t: screen_x expected %0d got %0d", $time,
                                 e.screen_x, out_data.screen_x);
                        fail_count++;
                    end
                    if (out_data.screen_y !== e.screen_y)
                    begin
                        $display("%0t: screen_y expected %0d got %0d", $time,
                                 e.screen_y, out_data.screen_y);
                        fail_count++;
                    end
                    if (out_data.depth_fault !== e.depth_fault)
                    begin
                        $display("%0t: depth_fault expected %0b got %0b", $time,
                                 e.depth_fault, out_data.depth_fault);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                screen_q.push_back(project_vertex(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    fdvp_pkg::CFG_COS_ANGLE:     cos_r = $signed(cfg_wdata);
                    fdvp_pkg::CFG_SIN_ANGLE:     sin_r = $signed(cfg_wdata);
                    fdvp_pkg::CFG_EYE_DISTANCE:  eye_r = cfg_wdata[14:0];
                    fdvp_pkg::CFG_CAMERA_OFFSET: cam_r = cfg_wdata[14:0];
                    fdvp_pkg::CFG_FOV_SCALE:     fov_r = cfg_wdata[14:0];
                    fdvp_pkg::CFG_SCREEN_SCALE:  scl_r = cfg_wdata[9:0];
                    fdvp_pkg::CFG_SCREEN_CENTER: ctr_r = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            pending = screen_q.size();
        end
    end

endmodule

// File: tb/tb_four_d_vertex_projector.sv
`timescale 1ns / 1ps

module tb_four_d_vertex_projector;

    localparam longint CYCLE_LIMIT = 400000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    fdvp_pkg::in_t                   in_data;
    logic                            out_valid;
    logic                            out_stall;
    fdvp_pkg::out_t                  out_data;
    logic                            cfg_we;
    logic [fdvp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fdvp_pkg::CFG_DATA_W-1:0] cfg_wdata;
    int                              fail_count;
    int                              pending;
    longint                          cycles;

    four_d_vertex_projector uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    fdvp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_four_d_vertex_projector: errors");
            $finish;
        end
    end

    // receiver stalls, with calm stretches
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
                @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic write_reg(logic [fdvp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // starts at a clock edge; with no gap the transaction follows the previous one directly
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] w, bit pace);
        int n;
        n = pace ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {x, y, z, w};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // mostly plausible geometry inside the view, some full-range noise
    function automatic logic [15:0] coord();
        if ($urandom_range(0, 9) < 7)
            return 16'($signed($urandom_range(0, 16384)) - 8192);
        return 16'($urandom);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_vertex(coord(), coord(), coord(), coord(), 1'b1);
    endtask

    task automatic set_angle(int c, int s);
        write_reg(fdvp_pkg::CFG_COS_ANGLE, 16'(c));
        write_reg(fdvp_pkg::CFG_SIN_ANGLE, 16'(s));
    endtask

    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycles    = 0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: origin, extremes, 4D eye fault, camera-plane fault, saturation
        send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h1000, 16'h0000, 16'h0000, 16'h2000, 1'b0);
        send_vertex(16'h1000, 16'h0000, 16'h0000, 16'h3000, 1'b0);
        send_vertex(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h5000, 16'h1000, 16'h0000, 1'b0);
        send_vertex(16'h7fff, 16'hc000, 16'h8000, 16'h1fff, 1'b0);
        send_vertex(16'h8000, 16'hb001, 16'h7fff, 16'h8000, 1'b0);
        send_vertex(16'h0800, 16'hf800, 16'hf000, 16'h1000, 1'b0);
        drain();

        random_phase(250);
        drain();

        // 45 degrees, and out-of-range trig values
        set_angle(11585, 11585);
        write_reg(fdvp_pkg::CFG_EYE_DISTANCE, 16'd16384);
        write_reg(fdvp_pkg::CFG_CAMERA_OFFSET, 16'd12288);
        write_reg(fdvp_pkg::CFG_FOV_SCALE, 16'd16384);
        random_phase(200);
        drain();

        set_angle(-16384, 16384);
        write_reg(fdvp_pkg::CFG_EYE_DISTANCE, 16'h7fff);
        write_reg(fdvp_pkg::CFG_CAMERA_OFFSET, 16'h7fff);
        write_reg(fdvp_pkg::CFG_FOV_SCALE, 16'h7fff);
        write_reg(fdvp_pkg::CFG_SCREEN_SCALE, 16'd1023);
        write_reg(fdvp_pkg::CFG_SCREEN_CENTER, 16'd1023);
        random_phase(200);
        drain();

        // zero registers: each vertex faults on the 4D or 3D divide or projects to (0, 0)
        set_angle(16'h8000, 16'h7fff);
        write_reg(fdvp_pkg::CFG_EYE_DISTANCE, 16'd0);
        write_reg(fdvp_pkg::CFG_CAMERA_OFFSET, 16'd0);
        write_reg(fdvp_pkg::CFG_FOV_SCALE, 16'd0);
        write_reg(fdvp_pkg::CFG_SCREEN_SCALE, 16'd0);
        write_reg(fdvp_pkg::CFG_SCREEN_CENTER, 16'd0);
        random_phase(100);
        drain();

        write_reg(3'd7, 16'hffff);
        for (int p = 0; p < 3; p++)
        begin
            set_angle($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
            write_reg(fdvp_pkg::CFG_EYE_DISTANCE, 16'($urandom));
            write_reg(fdvp_pkg::CFG_CAMERA_OFFSET, 16'($urandom));
            write_reg(fdvp_pkg::CFG_FOV_SCALE, 16'($urandom));
            write_reg(fdvp_pkg::CFG_SCREEN_SCALE, 16'($urandom));
            write_reg(fdvp_pkg::CFG_SCREEN_CENTER, 16'($urandom));
            random_phase(150);
            drain();
        end

        if (fail_count == 0)
            $display("tb_four_d_vertex_projector: clean");
        else
            $display("tb_four_d_vertex_projector: errors");
        $finish;
    end

endmodule
